>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL file stdisp_ctrl.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold on every rising clock edge outside reset
`define CHK_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
// condition must never be true outside reset
`define CHK_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (!(cond))) else $error(msg);
`else
`define CHK_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define CHK_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif
`endif

>>> src/stdisp_pkg.sv
// ----------------------------------------------------------------------------
// stdisp_pkg
// Types, codes and sizes of the subscription table dispatch block.
// ----------------------------------------------------------------------------
`default_nettype none

package stdisp_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [NRES_W-1:0] nres_t;

    localparam logic [1:0] CMD_SUBSCRIBE   = 2'd0;
    localparam logic [1:0] CMD_UNSUBSCRIBE = 2'd1;
    localparam logic [1:0] CMD_PUBLISH     = 2'd2;

    localparam logic [1:0] STS_DONE     = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_MATCH    = 2'd2;
    localparam logic [1:0] STS_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] message_id;
        logic [15:0] handler_code;
        logic [31:0] user_tag;
        logic [3:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_number;
        logic [15:0] handler_out;
        logic [31:0] tag_out;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] message_id;
        logic [15:0] handler_code;
        logic [31:0] user_tag;
    } slot_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    function automatic logic [3:0] slot_num(input idx_t idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[3:0];
    endfunction

endpackage

`default_nettype wire

>>> src/stdisp_ram.sv
// ----------------------------------------------------------------------------
// stdisp_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stdisp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/stdisp_ctrl.sv
// ----------------------------------------------------------------------------
// stdisp_ctrl
// Sequencer and shared slot compare unit: scans the table one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stdisp_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire stdisp_pkg::req_t         req,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output stdisp_pkg::rsp_t              res,
    output logic                          ram_we,
    output stdisp_pkg::idx_t              ram_waddr,
    output stdisp_pkg::slot_entry_t       ram_wdata,
    output stdisp_pkg::idx_t              ram_raddr,
    input  wire stdisp_pkg::slot_entry_t  ram_rdata
);

    stdisp_pkg::state_t state_reg, state_next;

    logic [stdisp_pkg::SLOT_COUNT-1:0] used_reg, used_next;
    stdisp_pkg::cnt_t  scan_idx_reg, scan_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    stdisp_pkg::idx_t  cmp_idx_reg, cmp_idx_next;
    stdisp_pkg::nres_t nres_reg, nres_next;
    logic              pend_vld_reg, pend_vld_next;
    stdisp_pkg::rsp_t  pend_reg, pend_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [31:0]       mid_reg, mid_next;
    logic [15:0]       hcode_reg, hcode_next;
    logic [31:0]       tag_reg, tag_next;

    logic is_pub;
    logic cmp_used;
    logic hit_sub;
    logic hit_pub;
    logic hit;
    logic stall;
    logic scan_end;
    logic cap;
    logic finish_hit;
    logic issue;

    assign is_pub   = (cmd_reg == stdisp_pkg::CMD_PUBLISH);
    assign cmp_used = used_reg[cmp_idx_reg];
    assign hit_sub  = cmp_vld_reg && !cmp_used;
    assign hit_pub  = cmp_vld_reg && cmp_used && (ram_rdata.message_id == mid_reg)
                      && (ram_rdata.handler_code != 16'd0);
    assign hit      = is_pub ? hit_pub : hit_sub;
    assign stall    = (state_reg == stdisp_pkg::S_SCAN) && is_pub && hit_pub
                      && pend_vld_reg && !res_ready;
    assign scan_end = (state_reg == stdisp_pkg::S_SCAN) && !cmp_vld_reg
                      && (scan_idx_reg == stdisp_pkg::cnt_t'(stdisp_pkg::SLOT_COUNT));
    assign cap      = is_pub && hit_pub
                      && (nres_reg == stdisp_pkg::nres_t'(stdisp_pkg::MAX_RESULTS - 1));
    assign finish_hit = (state_reg == stdisp_pkg::S_SCAN) && !stall && hit
                        && (!is_pub || cap);
    assign issue    = (state_reg == stdisp_pkg::S_SCAN) && !stall && !finish_hit
                      && (scan_idx_reg != stdisp_pkg::cnt_t'(stdisp_pkg::SLOT_COUNT));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stdisp_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.command)
                        stdisp_pkg::CMD_SUBSCRIBE:   state_next = stdisp_pkg::S_SCAN;
                        stdisp_pkg::CMD_PUBLISH:     state_next = stdisp_pkg::S_SCAN;
                        stdisp_pkg::CMD_UNSUBSCRIBE: state_next = stdisp_pkg::S_FLUSH;
                        default:                     state_next = stdisp_pkg::S_IDLE;
                    endcase
                end
            end
            stdisp_pkg::S_SCAN:
            begin
                if (finish_hit || scan_end)
                begin
                    state_next = stdisp_pkg::S_FLUSH;
                end
            end
            stdisp_pkg::S_FLUSH:
            begin
                if (res_ready)
                begin
                    state_next = stdisp_pkg::S_IDLE;
                end
            end
            default: state_next = stdisp_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        used_next     = used_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        nres_next     = nres_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        cmd_next      = cmd_reg;
        mid_next      = mid_reg;
        hcode_next    = hcode_reg;
        tag_next      = tag_reg;
        req_ready     = 1'b0;
        res_valid     = 1'b0;
        res           = pend_reg;
        res.last      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cmp_idx_reg;
        ram_wdata     = '{message_id: mid_reg, handler_code: hcode_reg, user_tag: tag_reg};
        ram_raddr     = stall ? cmp_idx_reg : scan_idx_reg[stdisp_pkg::IDX_W-1:0];

        case (state_reg)
            stdisp_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next      = req.command;
                    mid_next      = req.message_id;
                    hcode_next    = req.handler_code;
                    tag_next      = req.user_tag;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    nres_next     = '0;
                    pend_vld_next = 1'b0;
                    if (req.command == stdisp_pkg::CMD_UNSUBSCRIBE)
                    begin
                        for (int i = 0; i < stdisp_pkg::SLOT_COUNT; i++)
                        begin
                            if (32'(req.slot_index) == i)
                            begin
                                used_next[i] = 1'b0;
                            end
                        end
                        pend_next = '{status: stdisp_pkg::STS_DONE,
                                      slot_number: req.slot_index,
                                      handler_out: 16'd0, tag_out: 32'd0, last: 1'b0};
                        pend_vld_next = 1'b1;
                    end
                end
            end
            stdisp_pkg::S_SCAN:
            begin
                if (!stall)
                begin
                    cmp_vld_next = issue;
                    cmp_idx_next = scan_idx_reg[stdisp_pkg::IDX_W-1:0];
                    if (issue)
                    begin
                        scan_idx_next = scan_idx_reg + stdisp_pkg::cnt_t'(1);
                    end
                    if (is_pub && hit_pub)
                    begin
                        // push the previous match, hold the new one
                        res_valid     = pend_vld_reg;
                        pend_next     = '{status: stdisp_pkg::STS_MATCH,
                                          slot_number: stdisp_pkg::slot_num(cmp_idx_reg),
                                          handler_out: ram_rdata.handler_code,
                                          tag_out: ram_rdata.user_tag, last: 1'b0};
                        pend_vld_next = 1'b1;
                        nres_next     = nres_reg + stdisp_pkg::nres_t'(1);
                    end
                    if (!is_pub && hit_sub)
                    begin
                        ram_we = 1'b1;
                        for (int i = 0; i < stdisp_pkg::SLOT_COUNT; i++)
                        begin
                            if (32'(cmp_idx_reg) == i)
                            begin
                                used_next[i] = 1'b1;
                            end
                        end
                        pend_next     = '{status: stdisp_pkg::STS_DONE,
                                          slot_number: stdisp_pkg::slot_num(cmp_idx_reg),
                                          handler_out: 16'd0, tag_out: 32'd0, last: 1'b0};
                        pend_vld_next = 1'b1;
                    end
                    if (scan_end && !pend_vld_reg)
                    begin
                        pend_next     = '{status: is_pub ? stdisp_pkg::STS_NO_MATCH
                                                         : stdisp_pkg::STS_FULL,
                                          slot_number: 4'd0, handler_out: 16'd0,
                                          tag_out: 32'd0, last: 1'b0};
                        pend_vld_next = 1'b1;
                    end
                end
            end
            stdisp_pkg::S_FLUSH:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (res_ready)
                begin
                    pend_vld_next = 1'b0;
                end
            end
            default:
            begin
                pend_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stdisp_pkg::S_IDLE;
            used_reg     <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            nres_reg     <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            nres_reg     <= nres_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        pend_reg    <= pend_next;
        cmd_reg     <= cmd_next;
        mid_reg     <= mid_next;
        hcode_reg   <= hcode_next;
        tag_reg     <= tag_next;
    end

    `CHK_ASSERT(a_idle_no_pend, clk, rst_n, (state_reg == stdisp_pkg::S_IDLE) |-> !pend_vld_reg, "pending result left in idle")
    `CHK_ASSERT(a_flush_has_pend, clk, rst_n, (state_reg == stdisp_pkg::S_FLUSH) |-> pend_vld_reg, "flush without pending result")
    `CHK_ASSERT(a_stall_hold, clk, rst_n, stall |=> (cmp_vld_reg && $stable(cmp_idx_reg)), "compare slot lost during stall")
    `CHK_NEVER(a_nres_cap, clk, rst_n, nres_reg > stdisp_pkg::nres_t'(stdisp_pkg::MAX_RESULTS), "too many results")

endmodule

`default_nettype wire

>>> src/subscription_table_dispatch.sv
// Publish and a subscribe to a full table compare every slot before the last result; a
// subscribe that finds a free slot stops there. Unsubscribe goes straight to the flush.
// One slot is compared per cycle while the result side does not stall.
// A new request is taken only in idle, so requests pass one at a time through the idle, issue,
// slot scan, end and flush steps; stalls on the result side hold the scan.
// Reset: asynchronous, active low; clears all used marks, table contents stay undefined.
// ----------------------------------------------------------------------------
// subscription_table_dispatch
// Subscription table with publish dispatch and a registered result output.
// ----------------------------------------------------------------------------
`default_nettype none

module subscription_table_dispatch (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire stdisp_pkg::req_t  req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output stdisp_pkg::rsp_t       rsp
);

    logic                    res_valid;
    logic                    res_ready;
    stdisp_pkg::rsp_t        res;
    logic                    ram_we;
    stdisp_pkg::idx_t        ram_waddr;
    stdisp_pkg::slot_entry_t ram_wdata;
    stdisp_pkg::idx_t        ram_raddr;
    stdisp_pkg::slot_entry_t ram_rdata;

    logic             rsp_valid_reg, rsp_valid_next;
    stdisp_pkg::rsp_t rsp_reg, rsp_next;

    stdisp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    stdisp_ram #(
        .WIDTH ($bits(stdisp_pkg::slot_entry_t)),
        .DEPTH (stdisp_pkg::SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
